FILE: sv/complex_fixed_point_alu_top_macros.svh
// ----------------------------------------------------------------------------
// Complex ALU assertion macros
// Shorthand for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIXED_POINT_ALU_TOP_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define CFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Complex ALU package
// Operation codes, control bundle and the shared saturation function.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int CMD_W = 3;
  localparam int MAX_W = 64;
  localparam int MAG_W = 2 * MAX_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
  } ctl_t;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [MAX_W-1:0] val;
    logic             ovf;
  } sat_t;

  localparam mag_t MAG_ONE = mag_t'(1);

  // Clamp a sign/magnitude value to a w-bit two's complement word.
  function automatic sat_t saturate(input logic neg, input mag_t mag, input int unsigned w);
    mag_t lim;
    mag_t clip;
    mag_t twos;
    sat_t r;
    lim = MAG_ONE << (w - 1);
    if (!neg) begin
      lim = lim - MAG_ONE;
    end
    r.ovf = mag > lim;
    clip  = r.ovf ? lim : mag;
    twos  = neg ? (mag_t'(0) - clip) : clip;
    r.val = twos[MAX_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/cfa_in_if.sv
// ----------------------------------------------------------------------------
// Complex ALU operand channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface cfa_in_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::CMD_W-1:0]     cmd;
  logic signed [DATA_WIDTH-1:0]  a_re;
  logic signed [DATA_WIDTH-1:0]  a_im;
  logic signed [DATA_WIDTH-1:0]  b_re;
  logic signed [DATA_WIDTH-1:0]  b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: sv/cfa_out_if.sv
// ----------------------------------------------------------------------------
// Complex ALU result channel
// Valid/ready channel carrying the complex result and its status flags.
// ----------------------------------------------------------------------------
interface cfa_out_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  res_re;
  logic signed [DATA_WIDTH-1:0]  res_im;
  logic                          overflow;
  logic                          divide_by_zero;

  modport source (output valid, res_re, res_im, overflow, divide_by_zero, input ready);
  modport sink (input valid, res_re, res_im, overflow, divide_by_zero, output ready);
endinterface

FILE: sv/complex_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// Complex fixed-point ALU
// Add, subtract, multiply, divide, conjugate and magnitude on signed
// fixed-point complex operands, with saturation and status flags.
// ----------------------------------------------------------------------------
// One operand beat is taken every cycle unless the output stalls. Each result
// passes the front end, the DATA_WIDTH+1 quotient-bit stages of the divider
// (which every operation passes alongside) and the output register. The whole
// pipe holds while a result beat waits at the output, so operand ready drops
// only then.
module complex_fixed_point_alu_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic   clk,
  input logic   rst,
  cfa_in_if.sink    operand,
  cfa_out_if.source result
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int QB = W + 1;

  logic          adv;
  cfa_pkg::ctl_t f_ctl;
  logic [W-1:0]  f_re, f_im;
  logic          f_ovf, f_zd, nneg_re, nneg_im;
  logic [PW-1:0] nmag_re, nmag_im, den, msq;
  logic [W:0]    q_re, q_im, root;
  logic          big_re, big_im, neg_re, neg_im;

  cfa_pkg::ctl_t dl_ctl [QB];
  logic [W-1:0]  dl_re  [QB];
  logic [W-1:0]  dl_im  [QB];
  logic          dl_ovf [QB];
  logic          dl_zd  [QB];

  // Advance everything unless the output beat is stuck.
  assign adv           = !result.valid || result.ready;
  assign operand.ready = adv;

  cfa_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (operand.valid),
    .in_cmd   (operand.cmd),
    .in_a_re  (operand.a_re),
    .in_a_im  (operand.a_im),
    .in_b_re  (operand.b_re),
    .in_b_im  (operand.b_im),
    .out_ctl  (f_ctl),
    .fin_re   (f_re),
    .fin_im   (f_im),
    .fin_ovf  (f_ovf),
    .zero_den (f_zd),
    .nneg_re  (nneg_re),
    .nneg_im  (nneg_im),
    .nmag_re  (nmag_re),
    .nmag_im  (nmag_im),
    .den      (den),
    .msq      (msq)
  );

  cfa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk    (clk),
    .adv    (adv),
    .in_neg (nneg_re),
    .in_mag (nmag_re),
    .in_den (den),
    .quo    (q_re),
    .big    (big_re),
    .neg    (neg_re)
  );

  cfa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk    (clk),
    .adv    (adv),
    .in_neg (nneg_im),
    .in_mag (nmag_im),
    .in_den (den),
    .quo    (q_im),
    .big    (big_im),
    .neg    (neg_im)
  );

  cfa_sqrt #(.DATA_WIDTH(DATA_WIDTH)) u_sqrt (
    .clk   (clk),
    .adv   (adv),
    .in_sq (msq),
    .root  (root)
  );

  // Carry control and the early results past the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QB; k++) begin
        dl_ctl[k] <= '0;
      end
    end else if (adv) begin
      dl_ctl[0] <= f_ctl;
      for (int k = 1; k < QB; k++) begin
        dl_ctl[k] <= dl_ctl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_re[0]  <= f_re;
      dl_im[0]  <= f_im;
      dl_ovf[0] <= f_ovf;
      dl_zd[0]  <= f_zd;
      for (int k = 1; k < QB; k++) begin
        dl_re[k]  <= dl_re[k-1];
        dl_im[k]  <= dl_im[k-1];
        dl_ovf[k] <= dl_ovf[k-1];
        dl_zd[k]  <= dl_zd[k-1];
      end
    end
  end

  cfa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_ctl         (dl_ctl[QB-1]),
    .fin_re         (dl_re[QB-1]),
    .fin_im         (dl_im[QB-1]),
    .fin_ovf        (dl_ovf[QB-1]),
    .zero_den       (dl_zd[QB-1]),
    .q_re           (q_re),
    .big_re         (big_re),
    .neg_re         (neg_re),
    .q_im           (q_im),
    .big_im         (big_im),
    .neg_im         (neg_im),
    .root           (root),
    .out_valid      (result.valid),
    .res_re         (result.res_re),
    .res_im         (result.res_im),
    .overflow       (result.overflow),
    .divide_by_zero (result.divide_by_zero)
  );

endmodule

FILE: sv/cfa_front.sv
// ----------------------------------------------------------------------------
// Complex ALU front end
// Four stages: operand capture, products, sums, then magnitudes and the
// saturated results of add, subtract, conjugate and multiply.
// ----------------------------------------------------------------------------
module cfa_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [cfa_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [DATA_WIDTH-1:0]  in_a_re,
  input  logic signed [DATA_WIDTH-1:0]  in_a_im,
  input  logic signed [DATA_WIDTH-1:0]  in_b_re,
  input  logic signed [DATA_WIDTH-1:0]  in_b_im,
  output cfa_pkg::ctl_t                 out_ctl,
  output logic [DATA_WIDTH-1:0]         fin_re,
  output logic [DATA_WIDTH-1:0]         fin_im,
  output logic                          fin_ovf,
  output logic                          zero_den,
  output logic                          nneg_re,
  output logic                          nneg_im,
  output logic [2*DATA_WIDTH-1:0]       nmag_re,
  output logic [2*DATA_WIDTH-1:0]       nmag_im,
  output logic [2*DATA_WIDTH-1:0]       den,
  output logic [2*DATA_WIDTH-1:0]       msq
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;

  cfa_pkg::ctl_t a_ctl, b_ctl, c_ctl;

  logic signed [W-1:0]  a_re, a_im, b_re, b_im;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_aa_r, p_aa_i, p_bb_r, p_bb_i;
  logic signed [W:0]    s_re, s_im, b_sre, b_sim, c_sre, c_sim;
  logic signed [SW-1:0] c_mre, c_mim, c_nre, c_nim;
  logic [PW-1:0]        c_den, c_msq;

  logic                 m_re_neg, m_im_neg, s_re_neg, s_im_neg;
  logic [SW-1:0]        m_re_mag, m_im_mag, n_re_abs, n_im_abs;
  logic [W:0]           s_re_mag, s_im_mag;
  cfa_pkg::sat_t        m_re_sat, m_im_sat, s_re_sat, s_im_sat;
  logic [W-1:0]         fin_re_next, fin_im_next;
  logic                 fin_ovf_next;

  // Control advances with the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      b_ctl   <= '0;
      c_ctl   <= '0;
      out_ctl <= '0;
    end else if (adv) begin
      a_ctl   <= '{valid: in_valid, cmd: in_cmd};
      b_ctl   <= a_ctl;
      c_ctl   <= b_ctl;
      out_ctl <= c_ctl;
    end
  end

  // Add and subtract need one adder per component; conjugate only negates the imaginary part.
  always_comb begin
    s_re = '0;
    s_im = '0;
    case (a_ctl.cmd)
      cfa_pkg::CMD_ADD: begin
        s_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
        s_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end
      cfa_pkg::CMD_SUB: begin
        s_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
        s_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end
      cfa_pkg::CMD_CONJ: begin
        s_re = {a_re[W-1], a_re};
        s_im = -{a_im[W-1], a_im};
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_re   <= in_a_re;
      a_im   <= in_a_im;
      b_re   <= in_b_re;
      b_im   <= in_b_im;

      p_rr   <= a_re * b_re;
      p_ii   <= a_im * b_im;
      p_ir   <= a_im * b_re;
      p_ri   <= a_re * b_im;
      p_aa_r <= a_re * a_re;
      p_aa_i <= a_im * a_im;
      p_bb_r <= b_re * b_re;
      p_bb_i <= b_im * b_im;
      b_sre  <= s_re;
      b_sim  <= s_im;

      c_mre  <= SW'(p_rr) - SW'(p_ii);
      c_mim  <= SW'(p_ir) + SW'(p_ri);
      c_nre  <= SW'(p_rr) + SW'(p_ii);
      c_nim  <= SW'(p_ir) - SW'(p_ri);
      c_den  <= $unsigned(p_bb_r) + $unsigned(p_bb_i);
      c_msq  <= $unsigned(p_aa_r) + $unsigned(p_aa_i);
      c_sre  <= b_sre;
      c_sim  <= b_sim;
    end
  end

  // Truncate toward zero: shift the magnitude, then restore the sign.
  assign m_re_neg = c_mre[SW-1];
  assign m_im_neg = c_mim[SW-1];
  assign m_re_mag = m_re_neg ? $unsigned(-c_mre) : $unsigned(c_mre);
  assign m_im_mag = m_im_neg ? $unsigned(-c_mim) : $unsigned(c_mim);
  assign m_re_sat = cfa_pkg::saturate(m_re_neg, cfa_pkg::mag_t'(m_re_mag >> FRAC_BITS), W);
  assign m_im_sat = cfa_pkg::saturate(m_im_neg, cfa_pkg::mag_t'(m_im_mag >> FRAC_BITS), W);

  assign s_re_neg = c_sre[W];
  assign s_im_neg = c_sim[W];
  assign s_re_mag = s_re_neg ? $unsigned(-c_sre) : $unsigned(c_sre);
  assign s_im_mag = s_im_neg ? $unsigned(-c_sim) : $unsigned(c_sim);
  assign s_re_sat = cfa_pkg::saturate(s_re_neg, cfa_pkg::mag_t'(s_re_mag), W);
  assign s_im_sat = cfa_pkg::saturate(s_im_neg, cfa_pkg::mag_t'(s_im_mag), W);

  assign n_re_abs = c_nre[SW-1] ? $unsigned(-c_nre) : $unsigned(c_nre);
  assign n_im_abs = c_nim[SW-1] ? $unsigned(-c_nim) : $unsigned(c_nim);

  always_comb begin
    fin_re_next  = '0;
    fin_im_next  = '0;
    fin_ovf_next = 1'b0;
    case (c_ctl.cmd)
      cfa_pkg::CMD_MUL: begin
        fin_re_next  = m_re_sat.val[W-1:0];
        fin_im_next  = m_im_sat.val[W-1:0];
        fin_ovf_next = m_re_sat.ovf | m_im_sat.ovf;
      end
      cfa_pkg::CMD_ADD, cfa_pkg::CMD_SUB, cfa_pkg::CMD_CONJ: begin
        fin_re_next  = s_re_sat.val[W-1:0];
        fin_im_next  = s_im_sat.val[W-1:0];
        fin_ovf_next = s_re_sat.ovf | s_im_sat.ovf;
      end
      default: begin
        fin_re_next  = '0;
        fin_im_next  = '0;
        fin_ovf_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_re   <= fin_re_next;
      fin_im   <= fin_im_next;
      fin_ovf  <= fin_ovf_next;
      zero_den <= (c_den == '0);
      nneg_re  <= c_nre[SW-1];
      nneg_im  <= c_nim[SW-1];
      nmag_re  <= n_re_abs[PW-1:0];
      nmag_im  <= n_im_abs[PW-1:0];
      den      <= c_den;
      msq      <= c_msq;
    end
  end

endmodule

FILE: sv/cfa_div.sv
// ----------------------------------------------------------------------------
// Complex ALU pipelined divider
// Restoring divide of (magnitude << FRAC_BITS) by the divisor, one quotient
// bit per stage. An early compare flags quotients too wide to represent.
// ----------------------------------------------------------------------------
module cfa_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic                      in_neg,
  input  logic [2*DATA_WIDTH-1:0]   in_mag,
  input  logic [2*DATA_WIDTH-1:0]   in_den,
  output logic [DATA_WIDTH:0]       quo,
  output logic                      big,
  output logic                      neg
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int QB = W + 1;
  localparam int XW = PW + FRAC_BITS;

  logic [XW-1:0] dividend;
  logic [XW-1:0] hi_part;
  logic          init_big;

  logic [PW-1:0] rr [QB];
  logic [PW-1:0] dd [QB];
  logic [QB-1:0] lo [QB];
  logic [QB-1:0] qq [QB];
  logic          ng [QB];
  logic          bg [QB];

  assign dividend = XW'(in_mag) << FRAC_BITS;
  assign hi_part  = dividend >> QB;
  // Quotient needs more than QB bits when the top part already reaches the divisor.
  assign init_big = hi_part >= XW'(in_den);

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [PW-1:0] r_in;
    logic [PW-1:0] d_in;
    logic [QB-1:0] lo_in;
    logic [QB-1:0] q_in;
    logic          ng_in;
    logic          bg_in;
    logic [PW:0]   t;
    logic [PW:0]   t_sub;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in  = hi_part[PW-1:0];
      assign d_in  = in_den;
      assign lo_in = dividend[QB-1:0];
      assign q_in  = '0;
      assign ng_in = in_neg;
      assign bg_in = init_big;
    end else begin : g_next
      assign r_in  = rr[k-1];
      assign d_in  = dd[k-1];
      assign lo_in = lo[k-1];
      assign q_in  = qq[k-1];
      assign ng_in = ng[k-1];
      assign bg_in = bg[k-1];
    end

    assign t     = {r_in, lo_in[QB-1]};
    assign take  = t >= {1'b0, d_in};
    assign t_sub = t - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rr[k] <= take ? t_sub[PW-1:0] : t[PW-1:0];
        dd[k] <= d_in;
        lo[k] <= lo_in << 1;
        qq[k] <= {q_in[QB-2:0], take};
        ng[k] <= ng_in;
        bg[k] <= bg_in;
      end
    end
  end

  assign quo = qq[QB-1];
  assign big = bg[QB-1];
  assign neg = ng[QB-1];

endmodule

FILE: sv/cfa_sqrt.sv
// ----------------------------------------------------------------------------
// Complex ALU pipelined square root
// Digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cfa_sqrt #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [2*DATA_WIDTH-1:0]   in_sq,
  output logic [DATA_WIDTH:0]       root
);

  localparam int W  = DATA_WIDTH;
  localparam int RB = W + 1;
  localparam int XW = 2 * RB;
  localparam int TW = RB + 2;

  logic [TW-1:0] rem  [RB];
  logic [RB-1:0] rt   [RB];
  logic [XW-1:0] rest [RB];

  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [TW-1:0] rem_in;
    logic [RB-1:0] rt_in;
    logic [XW-1:0] rest_in;
    logic [TW-1:0] t;
    logic [TW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign rest_in = XW'(in_sq);
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign rt_in   = rt[k-1];
      assign rest_in = rest[k-1];
    end

    // Bring down two bits and try root*4+1.
    assign t     = {rem_in[RB-1:0], rest_in[XW-1:XW-2]};
    assign trial = {rt_in, 2'b01};
    assign take  = t >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]  <= take ? (t - trial) : t;
        rt[k]   <= {rt_in[RB-2:0], take};
        rest[k] <= rest_in << 2;
      end
    end
  end

  assign root = rt[RB-1];

endmodule

FILE: sv/cfa_back.sv
// ----------------------------------------------------------------------------
// Complex ALU result stage
// Saturates quotient and root, picks the result by operation and holds it
// in the output register.
// ----------------------------------------------------------------------------
module cfa_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  cfa_pkg::ctl_t                in_ctl,
  input  logic [DATA_WIDTH-1:0]        fin_re,
  input  logic [DATA_WIDTH-1:0]        fin_im,
  input  logic                         fin_ovf,
  input  logic                         zero_den,
  input  logic [DATA_WIDTH:0]          q_re,
  input  logic                         big_re,
  input  logic                         neg_re,
  input  logic [DATA_WIDTH:0]          q_im,
  input  logic                         big_im,
  input  logic                         neg_im,
  input  logic [DATA_WIDTH:0]          root,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         overflow,
  output logic                         divide_by_zero
);

  localparam int W = DATA_WIDTH;

  cfa_pkg::sat_t d_re_sat, d_im_sat, r_sat;
  logic [W-1:0]  re_next, im_next;
  logic          ovf_next, dz_next;

  // A wide quotient is forced past the limit so it clamps.
  assign d_re_sat = cfa_pkg::saturate(neg_re, big_re ? '1 : cfa_pkg::mag_t'(q_re), W);
  assign d_im_sat = cfa_pkg::saturate(neg_im, big_im ? '1 : cfa_pkg::mag_t'(q_im), W);
  assign r_sat    = cfa_pkg::saturate(1'b0, cfa_pkg::mag_t'(root), W);

  always_comb begin
    re_next  = '0;
    im_next  = '0;
    ovf_next = 1'b0;
    dz_next  = 1'b0;
    case (in_ctl.cmd)
      cfa_pkg::CMD_DIV: begin
        if (zero_den) begin
          dz_next = 1'b1;
        end else begin
          re_next  = d_re_sat.val[W-1:0];
          im_next  = d_im_sat.val[W-1:0];
          ovf_next = d_re_sat.ovf | d_im_sat.ovf;
        end
      end
      cfa_pkg::CMD_MAG: begin
        re_next  = r_sat.val[W-1:0];
        ovf_next = r_sat.ovf;
      end
      default: begin
        re_next  = fin_re;
        im_next  = fin_im;
        ovf_next = fin_ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re         <= re_next;
      res_im         <= im_next;
      overflow       <= ovf_next;
      divide_by_zero <= dz_next;
    end
  end

endmodule

FILE: sv/cfa_chk.sv
// ----------------------------------------------------------------------------
// Complex ALU port checker
// Watches the top-level channels for handshake and flag consistency.
// ----------------------------------------------------------------------------
`include "complex_fixed_point_alu_top_macros.svh"

module cfa_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] res_re,
  input logic [DATA_WIDTH-1:0] res_im,
  input logic                  overflow,
  input logic                  divide_by_zero
);

  // A waiting result beat holds still.
  `CFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_re) && $stable(res_im) && $stable(overflow) && $stable(divide_by_zero), "result beat changed while stalled")

  // Operands are taken exactly when the output side can move.
  `CFA_ASSERT_NOW(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready), "operand ready does not follow output stall")

  // A zero divisor gives a clean zero result.
  `CFA_ASSERT_NOW(a_dz_zero, out_valid && divide_by_zero, res_re == '0 && res_im == '0 && !overflow, "divide by zero result not zero")

endmodule

bind complex_fixed_point_alu_top cfa_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (operand.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .res_re         (result.res_re),
  .res_im         (result.res_im),
  .overflow       (result.overflow),
  .divide_by_zero (result.divide_by_zero)
);
